// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_DUMP       = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        RS_PUSH_OK    = 3'd0,
        RS_POPPED     = 3'd1,
        RS_DUMP_ELEM  = 3'd2,
        RS_DUMP_EMPTY = 3'd3,
        RS_UNDERFLOW  = 3'd4,
        RS_OVERFLOW   = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // single-port memory access: en with we=0 is a read
    typedef struct packed {
        logic en;
        logic we;
    } t_mem_cmd;

    // result descriptor; the word comes from the memory read port when from_ram is set
    typedef struct packed {
        t_status status;
        logic    last;
        logic    from_ram;
    } t_res_info;

endpackage

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry ring.
// Slave channel: tuser carries the command (push front/rear, pop front/rear,
// dump), tdata the word to push. Master channel: tdata the popped or dumped
// word (zero otherwise), tuser the status, tlast marks the final result of a
// command.
// A result passes through the read stage and then the output register; a dump
// first enters the dump state, then each of its words takes the same path.
// Throughput: push and pop run back to back while the output keeps up; a dump
// holds the slave side until its last word has been read and streams one word
// per cycle while the output does not stall, paced by the single memory read port.
// Commands 5 to 7 are dropped without a result.
// Reset empties the queue (head and count cleared); memory contents are kept
// but never read before being written.
// When the receiver stalls, one result sits in the output register and one
// more in the stage behind it; after that the slave side deasserts tready and
// a dump pauses until the output drains.
module double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic signed [31:0]     s_axis_tdata,   // value
    input  logic [2:0]             s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic signed [31:0]     m_axis_tdata,   // value_res
    output logic [2:0]             m_axis_tuser,   // status
    output logic                   m_axis_tlast
);

    localparam int AW = $clog2(DEPTH);

    logic               rs_ready;
    logic               res_load;
    deq_pkg::t_res_info res_info;
    deq_pkg::t_mem_cmd  mem_cmd;
    logic [AW-1:0]      mem_addr;
    logic signed [31:0] mem_wdata;
    logic signed [31:0] mem_rdata;

    deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .i_rs_ready    (rs_ready),
        .o_res_load    (res_load),
        .o_res         (res_info),
        .o_mem_cmd     (mem_cmd),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata)
    );

    deq_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    deq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (res_load),
        .i_info        (res_info),
        .i_rd_data     (mem_rdata),
        .o_ready       (rs_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  deq_pkg::t_mem_cmd      i_cmd,
    input  logic [AW-1:0]          i_addr,
    input  logic signed [31:0]     i_wdata,
    output logic signed [31:0]     o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    // read data only changes on a read, so it holds while the result waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_cmd.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2:0]             s_axis_tuser,
    input  logic signed [31:0]     s_axis_tdata,
    input  logic                   i_rs_ready,
    output logic                   o_res_load,
    output deq_pkg::t_res_info     o_res,
    output deq_pkg::t_mem_cmd      o_mem_cmd,
    output logic [AW-1:0]          o_mem_addr,
    output logic signed [31:0]     o_mem_wdata
);

    localparam logic [CW:0] DEPTH_X = (CW + 1)'(DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [CW:0] sum);
        logic [CW:0] adj;
        adj = (sum >= DEPTH_X) ? sum - DEPTH_X : sum;
        return adj[AW-1:0];
    endfunction

    deq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;

    deq_pkg::t_op    op;
    logic            in_fire;
    logic            dump_go;
    logic            dump_last;
    logic            empty;
    logic            full;
    logic [CW:0]     head_x;
    logic [CW:0]     count_x;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   front_inc;
    logic [AW-1:0]   rear_push;
    logic [AW-1:0]   rear_pop;
    logic [AW-1:0]   dump_addr;

    assign op            = deq_pkg::t_op'(s_axis_tuser);
    assign s_axis_tready = (r_state == deq_pkg::S_IDLE) && i_rs_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign dump_go       = (r_state == deq_pkg::S_DUMP) && i_rs_ready;
    assign dump_last     = (r_idx + CW'(1)) == r_count;
    assign empty         = r_count == '0;
    assign full          = r_count == CW'(DEPTH);

    assign head_x    = (CW + 1)'(r_head);
    assign count_x   = (CW + 1)'(r_count);
    assign front_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign front_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign rear_push = f_wrap(head_x + count_x);
    assign rear_pop  = f_wrap(head_x + count_x - (CW + 1)'(1));
    assign dump_addr = f_wrap(head_x + (CW + 1)'(r_idx));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (in_fire && op == deq_pkg::OP_DUMP && !empty) begin
                    n_state = deq_pkg::S_DUMP;
                end
            end
            deq_pkg::S_DUMP: begin
                if (dump_go && dump_last) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: n_state = deq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        o_mem_cmd   = '0;
        o_mem_addr  = r_head;
        o_mem_wdata = s_axis_tdata;
        o_res_load  = 1'b0;
        o_res       = '{status: deq_pkg::RS_PUSH_OK, last: 1'b1, from_ram: 1'b0};
        if (in_fire) begin
            unique case (op)
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
                    o_res_load = 1'b1;
                    if (full) begin
                        o_res.status = deq_pkg::RS_OVERFLOW;
                    end else begin
                        o_mem_cmd = '{en: 1'b1, we: 1'b1};
                        n_count   = r_count + 1'b1;
                        if (op == deq_pkg::OP_PUSH_FRONT) begin
                            o_mem_addr = front_dec;
                            n_head     = front_dec;
                        end else begin
                            o_mem_addr = rear_push;
                        end
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR: begin
                    o_res_load = 1'b1;
                    if (empty) begin
                        o_res.status = deq_pkg::RS_UNDERFLOW;
                    end else begin
                        o_mem_cmd      = '{en: 1'b1, we: 1'b0};
                        o_res.status   = deq_pkg::RS_POPPED;
                        o_res.from_ram = 1'b1;
                        n_count        = r_count - 1'b1;
                        if (op == deq_pkg::OP_POP_FRONT) begin
                            o_mem_addr = r_head;
                            n_head     = front_inc;
                        end else begin
                            o_mem_addr = rear_pop;
                        end
                    end
                end
                deq_pkg::OP_DUMP: begin
                    n_idx = '0;
                    if (empty) begin
                        o_res_load   = 1'b1;
                        o_res.status = deq_pkg::RS_DUMP_EMPTY;
                    end
                end
                default: ;  // unused codes give nothing
            endcase
        end else if (dump_go) begin
            o_mem_cmd  = '{en: 1'b1, we: 1'b0};
            o_mem_addr = dump_addr;
            o_res_load = 1'b1;
            o_res      = '{status: deq_pkg::RS_DUMP_ELEM, last: dump_last, from_ram: 1'b1};
            n_idx      = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== sv/deq_out.sv =====
`timescale 1ns / 1ps

module deq_out (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  deq_pkg::t_res_info     i_info,
    input  logic signed [31:0]     i_rd_data,
    output logic                   o_ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic signed [31:0]     m_axis_tdata,   // value_res
    output logic [2:0]             m_axis_tuser,   // status
    output logic                   m_axis_tlast
);

    // stage 1 waits for the memory read; stage 2 is the output register
    logic               r_rs_valid;
    deq_pkg::t_res_info r_rs_info;
    logic               r_o_valid;
    logic signed [31:0] r_o_data;
    deq_pkg::t_status   r_o_status;
    logic               r_o_last;
    logic               move;

    assign move    = r_rs_valid && (!r_o_valid || m_axis_tready);
    assign o_ready = !r_rs_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_rs_valid <= 1'b1;
            end else if (move) begin
                r_rs_valid <= 1'b0;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rs_info <= i_info;
        end
        if (move) begin
            r_o_data   <= r_rs_info.from_ram ? i_rd_data : 32'sd0;
            r_o_status <= r_rs_info.status;
            r_o_last   <= r_rs_info.last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tlast  = r_o_last;

endmodule

// ===== sv/deq_checker.sv =====
`timescale 1ns / 1ps

module deq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic signed [31:0] s_axis_tdata,
    input logic [2:0]         s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic signed [31:0] m_axis_tdata,
    input logic [2:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // only popped and dumped words carry data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != deq_pkg::RS_POPPED
            && m_axis_tuser != deq_pkg::RS_DUMP_ELEM |-> m_axis_tdata == 32'sd0)
        else $error("nonzero data on a status-only result");

    // every result except a dump element closes its command
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != deq_pkg::RS_DUMP_ELEM |-> m_axis_tlast)
        else $error("single result without tlast");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output transfer changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// ===== dv/double_ended_queue_checker.sv =====
`timescale 1ns / 1ps

module double_ended_queue_checker #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic signed [31:0] s_axis_tdata,   // value
    input  logic [2:0]         s_axis_tuser,   // op
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic signed [31:0] m_axis_tdata,   // value_res
    input  logic [2:0]         m_axis_tuser,   // status
    input  logic               m_axis_tlast,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int IW = $clog2(DEPTH);

    typedef struct packed {
        logic signed [31:0] word;
        deq_pkg::t_status   status;
        logic               last;
    } t_deq_result;

    t_deq_result        results_due[$];
    logic signed [31:0] ring [DEPTH];
    logic [IW-1:0]      head_idx = '0;
    logic [IW:0]        fill_cnt = '0;
    int                 errors = 0;

    function automatic logic [IW-1:0] slot(input int offset);
        return IW'((int'(head_idx) + offset) % DEPTH);
    endfunction

    task automatic queue_result(input logic [31:0] word, input deq_pkg::t_status status,
                                input logic last);
        t_deq_result r;
        r.word   = word;
        r.status = status;
        r.last   = last;
        results_due.push_back(r);
    endtask

    // Advances the queue image by one command and lines up what it must produce.
    task automatic apply_command(input logic [2:0] op, input logic [31:0] word);
        logic [IW-1:0] at;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
                if (fill_cnt >= DEPTH) begin
                    queue_result('0, deq_pkg::RS_OVERFLOW, 1'b1);
                end else begin
                    if (op == deq_pkg::OP_PUSH_FRONT) begin
                        head_idx = slot(DEPTH - 1);
                        at = head_idx;
                    end else begin
                        at = slot(fill_cnt);
                    end
                    ring[at] = word;
                    fill_cnt = fill_cnt + 1'b1;
                    queue_result('0, deq_pkg::RS_PUSH_OK, 1'b1);
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR: begin
                if (fill_cnt == 0) begin
                    queue_result('0, deq_pkg::RS_UNDERFLOW, 1'b1);
                end else begin
                    if (op == deq_pkg::OP_POP_FRONT) begin
                        at = head_idx;
                        head_idx = slot(1);
                    end else begin
                        at = slot(fill_cnt - 1);
                    end
                    fill_cnt = fill_cnt - 1'b1;
                    queue_result(ring[at], deq_pkg::RS_POPPED, 1'b1);
                end
            end
            deq_pkg::OP_DUMP: begin
                if (fill_cnt == 0) begin
                    queue_result('0, deq_pkg::RS_DUMP_EMPTY, 1'b1);
                end else begin
                    for (int k = 0; k < fill_cnt; k++) begin
                        queue_result(ring[slot(k)], deq_pkg::RS_DUMP_ELEM, k == fill_cnt - 1);
                    end
                end
            end
            default: ;  // spare codes are dropped without a result
        endcase
    endtask

    // Results are checked before the same-edge command is applied; no command
    // can produce a result on the edge that takes it.
    always @(posedge i_clk) begin
        t_deq_result want;
        if (!i_rst_n) begin
            head_idx = '0;
            fill_cnt = '0;
            results_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: expected no result, actual word %0d status %0d last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = results_due.pop_front();
                    if (m_axis_tdata !== want.word || m_axis_tuser !== want.status ||
                        m_axis_tlast !== want.last) begin
                        errors++;
                        $display("%0t: expected %0d st %0d last %b, actual %0d st %0d last %b",
                                 $time, want.word, want.status, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tuser, s_axis_tdata);
        end
        o_fail_count <= errors;
        o_pending    <= results_due.size();
    end

endmodule

// ===== dv/double_ended_queue_test.sv =====
`timescale 1ns / 1ps

module double_ended_queue_test;

    localparam int QDEPTH      = 64;
    localparam int ITEM_TARGET = 250;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic signed [31:0] s_axis_tdata = '0;   // value
    logic [2:0]         s_axis_tuser = '0;   // op
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic signed [31:0] m_axis_tdata;        // value_res
    logic [2:0]         m_axis_tuser;        // status
    logic               m_axis_tlast;

    logic calm = 1'b0;   // no idling on either side while set
    int   fail_count;
    int   pending;
    int   occupancy = 0;
    int   sent = 0;

    double_ended_queue #(.DEPTH(QDEPTH)) DUT (.*);

    double_ended_queue_checker #(.DEPTH(QDEPTH)) result_check (
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .*
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(0, 1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
    endfunction

    // valid is only lowered inside an idle gap, so back-to-back transfers keep it high
    task automatic send_command(input logic [2:0] op, input logic [31:0] word);
        while (!calm && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: if (occupancy < QDEPTH) occupancy++;
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR:   if (occupancy > 0) occupancy--;
            default: ;
        endcase
        if (op <= deq_pkg::OP_DUMP) sent++;
        calm <= (sent >= 100 && sent < 160);
    endtask

    initial begin
        int kind;
        int seg;
        int r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-queue cases, extreme words, spare codes, head wrap via push front
        send_command(deq_pkg::OP_DUMP, pick_word());
        send_command(deq_pkg::OP_POP_FRONT, pick_word());
        send_command(deq_pkg::OP_POP_REAR, pick_word());
        send_command(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_command(deq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
        send_command(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_command(deq_pkg::OP_PUSH_REAR, 32'h0000_0000);
        send_command(deq_pkg::OP_PUSH_REAR, 32'h0000_0001);
        send_command(deq_pkg::OP_DUMP, pick_word());
        send_command(OP_SPARE_5, 32'hFFFF_FFFF);
        send_command(deq_pkg::OP_POP_REAR, pick_word());
        send_command(OP_SPARE_6, pick_word());
        send_command(deq_pkg::OP_POP_FRONT, pick_word());
        send_command(OP_SPARE_7, pick_word());
        send_command(deq_pkg::OP_POP_FRONT, pick_word());
        send_command(deq_pkg::OP_POP_REAR, pick_word());
        send_command(deq_pkg::OP_POP_REAR, pick_word());
        send_command(deq_pkg::OP_POP_FRONT, pick_word());
        send_command(deq_pkg::OP_DUMP, pick_word());
        send_command(deq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
        send_command(deq_pkg::OP_PUSH_REAR, 32'hAAAA_AAAA);
        send_command(deq_pkg::OP_DUMP, pick_word());
        send_command(deq_pkg::OP_POP_FRONT, pick_word());
        send_command(deq_pkg::OP_POP_FRONT, pick_word());

        // segments: fill to overflow, mixed traffic, drain to underflow, then random
        seg = 0;
        while (sent < ITEM_TARGET) begin
            kind = (seg < 3) ? seg : $urandom_range(0, 5);
            case (kind)
                0: begin
                    while (occupancy < QDEPTH)
                        send_command(pick_push(), pick_word());
                    repeat ($urandom_range(1, 3))
                        send_command(pick_push(), pick_word());
                    send_command(deq_pkg::OP_DUMP, pick_word());
                end
                2: begin
                    while (occupancy > 0)
                        send_command(pick_pop(), pick_word());
                    repeat ($urandom_range(1, 2))
                        send_command(pick_pop(), pick_word());
                    send_command(deq_pkg::OP_DUMP, pick_word());
                end
                default: begin
                    repeat ($urandom_range(20, 40)) begin
                        r = $urandom_range(0, 99);
                        if (r < 38)
                            send_command(pick_push(), pick_word());
                        else if (r < 76)
                            send_command(pick_pop(), pick_word());
                        else if (r < 90)
                            send_command(deq_pkg::OP_DUMP, pick_word());
                        else
                            send_command(3'(OP_SPARE_5 + $urandom_range(0, 2)), pick_word());
                    end
                end
            endcase
            seg++;
        end
        s_axis_tvalid <= 1'b0;
        calm <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
